@@ hw/rtl/psched_pkg.sv @@
// ----------------------------------------------------------------------------
// psched_pkg
// Shared constants and codes of the periodic id scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

	localparam int unsigned MAX_SOURCES_DEF = 64;
	localparam int unsigned DUE_WIDTH_DEF   = 48;
	localparam int unsigned ID_W            = 16;
	localparam int unsigned PER_W           = 16;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_ISSUE = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

endpackage

@@ hw/rtl/psched_if.sv @@
// ----------------------------------------------------------------------------
// psched_if
// Valid/ready channels of the scheduler: request and response beats.
// ----------------------------------------------------------------------------
interface psched_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] source_id;
	logic [15:0] period;

	modport source (output valid, kind, source_id, period, input ready);
	modport sink (input valid, kind, source_id, period, output ready);
endinterface

interface psched_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] issued_id;
	logic [1:0]  status;

	modport source (output valid, issued_id, status, input ready);
	modport sink (input valid, issued_id, status, output ready);
endinterface

@@ hw/rtl/psched_ram.sv @@
// ----------------------------------------------------------------------------
// psched_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module psched_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/periodic_id_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_id_scheduler
// Table of periodic sources in one RAM; issue scans for the earliest due time
// (smaller id, then lower slot on ties) and writes back the advanced due time.
// ----------------------------------------------------------------------------
//  channel | dir | payload                     | beat when
//  req     | in  | kind, source_id, period     | req.valid && req.ready
//  rsp     | out | issued_id, status           | rsp.valid && rsp.ready
//
// add and clear are handled while idle; issue scans the entries linearly through
// the single read port of the entry RAM.
// reset clears the entry count and the response valid flag; RAM and the response payload hold no reset.
// a request is taken only while idle and while the response register is free
// or being drained; a finished issue waits in write-back for that register.
// clear and kind 3 give no response beat.
// ----------------------------------------------------------------------------
module periodic_id_scheduler #(
	parameter int unsigned MAX_SOURCES = psched_pkg::MAX_SOURCES_DEF,
	parameter int unsigned DUE_WIDTH   = psched_pkg::DUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	psched_req_if.sink    req,
	psched_rsp_if.source  rsp
);

	localparam int unsigned IW = $clog2(MAX_SOURCES);
	localparam int unsigned CW = $clog2(MAX_SOURCES + 1);
	localparam int unsigned WW = psched_pkg::ID_W + psched_pkg::PER_W + DUE_WIDTH;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WB} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    scan_q;
	logic             issued_all_q;
	logic             rd_s1;
	logic [IW-1:0]    idx_s1;
	logic             last_s1;
	logic             first_q;
	logic [IW-1:0]    best_idx_q;
	logic [15:0]      best_id_q;
	logic [15:0]      best_per_q;
	logic [DUE_WIDTH-1:0] best_due_q;
	logic             rsp_valid_q;
	logic [15:0]      rsp_id_q;
	logic [1:0]       rsp_status_q;

	logic             ram_we, ram_re;
	logic [IW-1:0]    ram_waddr;
	logic [WW-1:0]    ram_wdata, ram_rdata;

	logic             out_free, acc;
	logic             rsp_set;
	logic [15:0]      r_id, r_per;
	logic [DUE_WIDTH-1:0] r_due, new_due;
	logic [DUE_WIDTH:0]   due_sum;
	logic             take;
	logic [IW-1:0]    last_idx;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc = req.valid && req.ready;
	assign last_idx = IW'(count_q - CW'(1));

	// response register loads on add, empty issue and issue write-back
	assign rsp_set = (acc && ((psched_pkg::kind_t'(req.kind) == psched_pkg::KIND_ADD) ||
		((psched_pkg::kind_t'(req.kind) == psched_pkg::KIND_ISSUE) && (count_q == '0)))) ||
		((state_q == S_WB) && out_free);

	// unpack read word and pick the running best
	assign {r_id, r_per, r_due} = ram_rdata;
	assign take = first_q || (r_due < best_due_q) ||
		((r_due == best_due_q) && (r_id < best_id_q));

	// saturating advance of the chosen due time
	assign due_sum = {1'b0, best_due_q} + (DUE_WIDTH+1)'(best_per_q);
	assign new_due = due_sum[DUE_WIDTH] ? {DUE_WIDTH{1'b1}} : due_sum[DUE_WIDTH-1:0];

	// ram port control
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = IW'(count_q);
		ram_wdata = {req.source_id, req.period, DUE_WIDTH'(req.period)};
		if (acc && psched_pkg::kind_t'(req.kind) == psched_pkg::KIND_ADD
			&& count_q != CW'(MAX_SOURCES)) begin
			ram_we = 1'b1;
		end else if (state_q == S_WB && out_free) begin
			ram_we = 1'b1;
			ram_waddr = best_idx_q;
			ram_wdata = {best_id_q, best_per_q, new_due};
		end
	end
	assign ram_re = (state_q == S_SCAN) && !issued_all_q;

	psched_ram #(.WIDTH(WW), .DEPTH(MAX_SOURCES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(scan_q), .rdata(ram_rdata)
	);

	// sequencer, table count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
			scan_q <= '0;
			issued_all_q <= 1'b0;
			rd_s1 <= 1'b0;
			idx_s1 <= '0;
			last_s1 <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (rsp_set) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			rd_s1 <= ram_re;
			idx_s1 <= scan_q;
			last_s1 <= (scan_q == last_idx);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (psched_pkg::kind_t'(req.kind))
							psched_pkg::KIND_ADD: begin
								rsp_id_q <= '0;
								if (count_q == CW'(MAX_SOURCES)) begin
									rsp_status_q <= psched_pkg::ST_FULL;
								end else begin
									rsp_status_q <= psched_pkg::ST_OK;
									count_q <= count_q + CW'(1);
								end
							end
							psched_pkg::KIND_ISSUE: begin
								if (count_q == '0) begin
									rsp_id_q <= '0;
									rsp_status_q <= psched_pkg::ST_EMPTY;
								end else begin
									state_q <= S_SCAN;
									scan_q <= '0;
									issued_all_q <= 1'b0;
									first_q <= 1'b1;
								end
							end
							psched_pkg::KIND_CLEAR: count_q <= '0;
							psched_pkg::KIND_NONE: ;
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						if (scan_q == last_idx) issued_all_q <= 1'b1;
						else scan_q <= scan_q + IW'(1);
					end
					if (rd_s1) begin
						first_q <= 1'b0;
						if (take) begin
							best_idx_q <= idx_s1;
							best_id_q <= r_id;
							best_per_q <= r_per;
							best_due_q <= r_due;
						end
						if (last_s1) state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						rsp_id_q <= best_id_q;
						rsp_status_q <= psched_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.issued_id = rsp_id_q;
	assign rsp.status = rsp_status_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SOURCES)) else $error("entry count beyond table size");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q && $stable(rsp_id_q))
		else $error("pending response lost");
	a_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB && out_free) |=> state_q == S_IDLE && rsp_valid_q)
		else $error("write-back without response");

endmodule
